### hw/rtl/fspp_pkg.sv
package fspp_pkg;
   localparam int SLOTS = 16;
   localparam int SLOT_BITS = 4;
   localparam int IDX_BITS = 5;
   localparam int RT_BITS = 32;
   localparam int PRIO_BITS = 3;
   localparam int SLICE_BITS = 8;

   localparam logic [2:0] CMD_ADD   = 3'd0;
   localparam logic [2:0] CMD_SETRUN = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_YIELD = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADSLOT = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;

   localparam logic [IDX_BITS-1:0] IDLE_IDX = IDX_BITS'(SLOTS);

   typedef struct packed {
      logic [2:0]           command;
      logic [SLOT_BITS-1:0] slot;
      logic [PRIO_BITS-1:0] prio;
      logic [RT_BITS-1:0]   runtime_start;
      logic                 runnable;
      logic                 preempt_blocked;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] running_slot;
      logic                switched;
      logic [1:0]          status;
   } rsp_type;

   // word handed from one cell to the next while a pick walks the row
   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
      logic [RT_BITS-1:0]  key;
      logic [PRIO_BITS-1:0] prio;
   } best_type;

   // control a cell sees from the sequencer
   typedef struct packed {
      logic                 write;
      logic                 set_run;
      logic                 clear;
      logic                 charge;
      logic                 run_val;
      logic [PRIO_BITS-1:0] prio;
      logic [RT_BITS-1:0]   runtime;
   } cell_ctl_type;
endpackage

### hw/rtl/fspp_cell.sv
module fspp_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  fspp_pkg::cell_ctl_type     ctl,
   input  logic [fspp_pkg::IDX_BITS-1:0] my_idx,
   input  logic                       scan,
   input  fspp_pkg::best_type         best_i,
   output fspp_pkg::best_type         best_o,
   output logic                       valid_o,
   output logic                       runnable_o
);
   import fspp_pkg::*;

   logic valid_ff, runnable_ff;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [RT_BITS-1:0] rt_ff;
   logic [RT_BITS-1:0] key;
   best_type best_ff, best_in;

   assign key = rt_ff >> prio_ff;

   always_comb begin
      best_in = best_i;
      if (valid_ff && runnable_ff && (!best_i.found || key < best_i.key)) begin
         best_in.found = 1'b1;
         best_in.idx = my_idx;
         best_in.key = key;
         best_in.prio = prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         runnable_ff <= 1'b0;
      end else begin
         if (ctl.write) begin
            valid_ff <= 1'b1;
            runnable_ff <= ctl.run_val;
         end else if (ctl.set_run) begin
            runnable_ff <= ctl.run_val;
         end else if (ctl.clear) begin
            valid_ff <= 1'b0;
            runnable_ff <= 1'b0;
         end
      end
      if (ctl.write) begin
         prio_ff <= ctl.prio;
         rt_ff <= ctl.runtime;
      end else if (ctl.charge && rt_ff != '1) begin
         rt_ff <= rt_ff + 1'b1;
      end
      if (scan) best_ff <= best_in;
   end

   assign best_o = best_ff;
   assign valid_o = valid_ff;
   assign runnable_o = runnable_ff;
endmodule

### hw/rtl/fair_share_process_picker_core.sv
// Fair-share process picker core.
// Command channel: drive req_word with start high while busy is low; the
// word is taken on that edge. Commands: add slot, set runnable, remove slot,
// timer tick, yield. Each command yields exactly one result word on rsp_word,
// marked by rsp_strobe for a single cycle; the receiver cannot stall it.
// Add, set runnable, remove, unknown codes and ticks that do not preempt
// go from the decode state straight to the result state. A pick (yield, or
// a tick whose slice ran out) walks the row of 16 slot cells, one cell per
// cycle through the registered best-so-far chain, then loads the winner
// and goes to the result state. busy stays high through the result strobe
// cycle, so the next command is taken only after the previous result.
// Reset (synchronous, active high): all slots empty, idle task running,
// slice zero, switch count zero. Slot priority and runtime are not reset:
// they are only read for slots an add has filled.
module fair_share_process_picker_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  fspp_pkg::req_type  req_word,
   output logic               rsp_strobe,
   output fspp_pkg::rsp_type  rsp_word
);
   import fspp_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff, state_in;
   req_type req_ff;
   logic [IDX_BITS-1:0] cur_ff, cur_in;
   logic [SLICE_BITS-1:0] slice_ff, slice_in;
   logic [31:0] switch_total_ff, switch_total_in;
   logic [SLOT_BITS:0] cnt_ff, cnt_in;
   logic switched_ff, switched_in;
   logic [1:0] status_ff, status_in;
   logic strobe_ff, strobe_in;

   cell_ctl_type ctl [SLOTS];
   best_type chain [SLOTS+1];
   logic [SLOTS-1:0] valid_v, run_v;
   logic scan;

   assign scan = (state_ff == S_SCAN);
   assign chain[0] = '0;

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         always_comb begin
            ctl[g] = '0;
            ctl[g].run_val = req_ff.runnable;
            ctl[g].prio = req_ff.prio;
            ctl[g].runtime = req_ff.runtime_start;
            if (state_ff == S_EXEC && req_ff.slot == SLOT_BITS'(g)) begin
               ctl[g].write = (req_ff.command == CMD_ADD) && !valid_v[g];
               ctl[g].set_run = (req_ff.command == CMD_SETRUN) && valid_v[g];
               ctl[g].clear = (req_ff.command == CMD_REMOVE) && valid_v[g]
                              && cur_ff != IDX_BITS'(g);
            end
            ctl[g].charge = (state_ff == S_EXEC) && (req_ff.command == CMD_TICK)
                            && cur_ff == IDX_BITS'(g);
         end
         fspp_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ctl[g]),
            .my_idx(IDX_BITS'(g)), .scan(scan),
            .best_i(chain[g]), .best_o(chain[g+1]),
            .valid_o(valid_v[g]), .runnable_o(run_v[g])
         );
      end
   endgenerate

   logic [SLOT_BITS-1:0] cur_slot;
   logic cur_is_task, cur_runnable;
   logic [SLICE_BITS-1:0] slice_dec;
   logic [IDX_BITS-1:0] pick_idx;
   logic [PRIO_BITS-1:0] pick_prio;

   always_comb begin
      cur_slot = cur_ff[SLOT_BITS-1:0];
      cur_is_task = (cur_ff != IDLE_IDX);
      cur_runnable = cur_is_task ? run_v[cur_slot] : 1'b1;
      slice_dec = (slice_ff != '0) ? slice_ff - 1'b1 : slice_ff;
      pick_idx = chain[SLOTS].found ? chain[SLOTS].idx : IDLE_IDX;
      pick_prio = chain[SLOTS].found ? chain[SLOTS].prio : '0;
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      slice_in = slice_ff;
      switch_total_in = switch_total_ff;
      cnt_in = cnt_ff;
      switched_in = switched_ff;
      status_in = status_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            status_in = ST_OK;
            switched_in = 1'b0;
            state_in = S_RESP;
            strobe_in = 1'b1;
            case (req_ff.command)
               CMD_ADD: if (valid_v[req_ff.slot]) status_in = ST_BADSLOT;
               CMD_SETRUN: if (!valid_v[req_ff.slot]) status_in = ST_BADSLOT;
               CMD_REMOVE: begin
                  if (!valid_v[req_ff.slot]) status_in = ST_BADSLOT;
                  else if (cur_ff == {1'b0, req_ff.slot}) status_in = ST_RUNNING;
               end
               CMD_TICK: begin
                  slice_in = slice_dec;
                  if (!req_ff.preempt_blocked && slice_dec == '0 && cur_runnable) begin
                     state_in = S_SCAN;
                     strobe_in = 1'b0;
                     cnt_in = '0;
                  end
               end
               CMD_YIELD: begin
                  state_in = S_SCAN;
                  strobe_in = 1'b0;
                  cnt_in = '0;
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (SLOT_BITS+1)'(SLOTS)) begin
               slice_in = SLICE_BITS'(9'd1 << pick_prio);
               if (pick_idx != cur_ff) begin
                  switched_in = 1'b1;
                  switch_total_in = switch_total_ff + 1'b1;
                  cur_in = pick_idx;
               end
               state_in = S_RESP;
               strobe_in = 1'b1;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_ff <= IDLE_IDX;
         slice_ff <= '0;
         switch_total_ff <= '0;
         strobe_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         slice_ff <= slice_in;
         switch_total_ff <= switch_total_in;
         strobe_ff <= strobe_in;
         cnt_ff <= cnt_in;
      end
      if (state_ff == S_IDLE && start) req_ff <= req_word;
      switched_ff <= switched_in;
      status_ff <= status_in;
   end

   // scan fills the chain cell by cell; the chain's last word lands at the end
   // the result is shown in S_RESP (one cycle), then busy drops
   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word.running_slot = cur_ff;
   assign rsp_word.switched = switched_ff;
   assign rsp_word.status = status_ff;

   a_strobe_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == S_RESP) else $error("strobe outside response");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe longer than one cycle");
   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= IDLE_IDX) else $error("current index out of range");
   a_running_valid: assert property (@(posedge clock) disable iff (reset)
      cur_ff != IDLE_IDX |-> valid_v[cur_slot]) else $error("running slot empty");
endmodule

### bench/tb_fair_share_process_picker_core.sv
`timescale 1ns / 100ps

module tb_fair_share_process_picker_core;
   import fspp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [RT_BITS-1:0] RT_TOP = {RT_BITS{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_word = '0;
   logic rsp_strobe;
   rsp_type rsp_word;

   fair_share_process_picker_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #4 clock = ~clock;

   // shadow copy of the scheduler table
   logic                 sh_valid [SLOTS];
   logic                 sh_run   [SLOTS];
   logic [PRIO_BITS-1:0] sh_prio  [SLOTS];
   logic [RT_BITS-1:0]   sh_rt    [SLOTS];
   logic [SLICE_BITS-1:0] sh_slice;
   logic [IDX_BITS-1:0]  sh_cur;

   rsp_type pending_rsp[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int picks_seen = 0;
   int idle_cycles = 0;
   int gap_pct = 17;

   // choose the runnable slot with least runtime >> prio; reload slice
   function automatic logic pick_next();
      logic [IDX_BITS-1:0] best;
      logic [RT_BITS-1:0]  best_key;
      logic [RT_BITS-1:0]  k;
      logic [PRIO_BITS-1:0] p;
      best = IDLE_IDX;
      best_key = '0;
      p = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (sh_valid[i] && sh_run[i]) begin
            k = sh_rt[i] >> sh_prio[i];
            if (best == IDLE_IDX || k < best_key) begin
               best = IDX_BITS'(i);
               best_key = k;
            end
         end
      end
      if (best != IDLE_IDX) p = sh_prio[best];
      sh_slice = SLICE_BITS'(1) << p;
      picks_seen++;
      if (best != sh_cur) begin
         sh_cur = best;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type schedule_word(req_type w);
      rsp_type r;
      logic running;
      r = '0;
      case (w.command)
         CMD_ADD: begin
            if (sh_valid[w.slot]) r.status = ST_BADSLOT;
            else begin
               sh_valid[w.slot] = 1'b1;
               sh_run[w.slot] = w.runnable;
               sh_prio[w.slot] = w.prio;
               sh_rt[w.slot] = w.runtime_start;
            end
         end
         CMD_SETRUN: begin
            if (!sh_valid[w.slot]) r.status = ST_BADSLOT;
            else sh_run[w.slot] = w.runnable;
         end
         CMD_REMOVE: begin
            if (!sh_valid[w.slot]) r.status = ST_BADSLOT;
            else if (IDX_BITS'(w.slot) == sh_cur) r.status = ST_RUNNING;
            else begin
               sh_valid[w.slot] = 1'b0;
               sh_run[w.slot] = 1'b0;
            end
         end
         CMD_TICK: begin
            running = 1'b1;
            if (sh_cur != IDLE_IDX) begin
               if (sh_rt[sh_cur] != RT_TOP) sh_rt[sh_cur] = sh_rt[sh_cur] + 1;
               running = sh_run[sh_cur];
            end
            if (sh_slice != 0) sh_slice = sh_slice - 1;
            if (!w.preempt_blocked && sh_slice == 0 && running)
               r.switched = pick_next();
         end
         CMD_YIELD: r.switched = pick_next();
         default: ;
      endcase
      r.running_slot = sh_cur;
      return r;
   endfunction

   // send one command word, with random gaps before it; start drops after
   // the accepting edge so the next word never lands in the same step
   task automatic send_word(req_type w);
      while ($urandom_range(99) < gap_pct) @(posedge clock);
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(schedule_word(w));
      words_sent++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type rand_word(int cmd);
      req_type w;
      w.command = 3'(cmd);
      w.slot = 4'($urandom_range(15));
      w.prio = 3'($urandom_range(7));
      case ($urandom_range(3))
         0: w.runtime_start = $urandom();
         1: w.runtime_start = RT_TOP - $urandom_range(3);
         default: w.runtime_start = $urandom_range(255);
      endcase
      w.runnable = ($urandom_range(3) != 0);
      w.preempt_blocked = ($urandom_range(4) == 0);
      return w;
   endfunction

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // result checker: strobe is sampled at the edge that ends its cycle
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            words_checked++;
            if (rsp_word.running_slot !== exp_rsp.running_slot) begin
               $error("running_slot exp %0d got %0d", exp_rsp.running_slot,
                      rsp_word.running_slot);
               errors++;
            end
            if (rsp_word.switched !== exp_rsp.switched) begin
               $error("switched exp %0d got %0d", exp_rsp.switched, rsp_word.switched);
               errors++;
            end
            if (rsp_word.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_word.status);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no accepted command and no result
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", pending_rsp.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // error cases, every command, extremes of each field
   task automatic test_directed();
      req_type w;
      w = '0;
      w.command = CMD_TICK;   send_word(w);          // tick while idle
      w.command = CMD_YIELD;  send_word(w);          // yield with empty table
      w.command = CMD_SETRUN; w.slot = 4'd3; send_word(w);  // empty slot
      w.command = CMD_REMOVE; send_word(w);                 // empty slot
      w = '{CMD_ADD, 4'd15, 3'd7, RT_TOP, 1'b1, 1'b0}; send_word(w);
      send_word(w);                                  // occupied slot
      w = '{CMD_ADD, 4'd0, 3'd0, 32'd0, 1'b1, 1'b1}; send_word(w);
      w = '{CMD_ADD, 4'd1, 3'd0, 32'd0, 1'b1, 1'b0}; send_word(w);  // tie
      w = '0; w.command = CMD_YIELD; send_word(w);
      w.command = CMD_REMOVE; w.slot = 4'd0; send_word(w);  // running slot
      w.command = CMD_TICK; w.preempt_blocked = 1'b1; send_word(w);
      w.preempt_blocked = 1'b0; send_word(w); send_word(w);
      w.command = CMD_SETRUN; w.slot = 4'd0; w.runnable = 1'b0; send_word(w);
      w.command = CMD_TICK; send_word(w); send_word(w);    // blocked keeps on
      w.command = CMD_YIELD; send_word(w);
      w = '{CMD_YIELD, 4'd15, 3'd0, 32'd0, 1'b0, 1'b0};
      w.command = CMD_SETRUN; w.slot = 4'd1; send_word(w);
      w.command = CMD_YIELD; send_word(w);                  // picks slot 15
      w.command = CMD_TICK; send_word(w); send_word(w);     // runtime saturated
      for (int c = 5; c < 8; c++) begin
         w = rand_word(c); send_word(w);                    // unknown codes
      end
   endtask

   // mostly ticks and yields over a populated table
   task automatic test_random(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 15) send_word(rand_word(CMD_ADD));
         else if (r < 28) send_word(rand_word(CMD_SETRUN));
         else if (r < 38) send_word(rand_word(CMD_REMOVE));
         else if (r < 78) send_word(rand_word(CMD_TICK));
         else if (r < 96) send_word(rand_word(CMD_YIELD));
         else send_word(rand_word($urandom_range(7, 5)));
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         sh_valid[i] = 1'b0;
         sh_run[i] = 1'b0;
         sh_prio[i] = '0;
         sh_rt[i] = '0;
      end
      sh_slice = '0;
      sh_cur = IDLE_IDX;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      gap_pct = 17;
      test_random(430);
      drain();                 // hold off until all results are in
      gap_pct = 58;
      test_random(430);
      gap_pct = 0;
      test_random(440);
      drain();
      repeat (20) @(posedge clock);
      $display("%0d command words sent, %0d results checked, %0d picks",
               words_sent, words_checked, picks_seen);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### files.f
hw/rtl/fspp_pkg.sv
hw/rtl/fspp_cell.sv
hw/rtl/fair_share_process_picker_core.sv
bench/tb_fair_share_process_picker_core.sv
